/* rtl/heartbeat_hsv_led_driver_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the heartbeat HSV LED driver
// Clocked, reset-qualified property checks that report through $error.
// ----------------------------------------------------------------------------
`ifndef HEARTBEAT_HSV_LED_DRIVER_ASSERT_SVH
`define HEARTBEAT_HSV_LED_DRIVER_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define HHLD_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hhld assertion failed");

// Condition must never be true outside reset.
`define HHLD_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("hhld forbidden condition seen");

`endif

/* rtl/hhld_pkg.sv */
// ----------------------------------------------------------------------------
// hhld_pkg
// Types, constants and arithmetic helpers shared by the LED driver modules.
// ----------------------------------------------------------------------------
package hhld_pkg;

  localparam logic [7:0]  SatReset    = 8'd255;
  localparam logic [7:0]  PeakReset   = 8'd30;
  localparam logic [13:0] HsvFull     = 14'd10710;
  localparam logic [5:0]  SectorMax   = 6'd42;
  localparam logic [7:0]  SectorWidth = 8'd43;
  localparam logic [7:0]  ValMax      = 8'd255;
  // floor(y / 21) == (y * Div21Mul) >> 16 for y below 13107
  localparam logic [11:0] Div21Mul    = 12'd3121;

  typedef enum logic {
    CfgSaturation = 1'b0,
    CfgPeakLevel  = 1'b1
  } hhld_cfg_e;

  typedef enum logic [2:0] {
    SecRed     = 3'd0,
    SecYellow  = 3'd1,
    SecGreen   = 3'd2,
    SecCyan    = 3'd3,
    SecBlue    = 3'd4,
    SecMagenta = 3'd5
  } hhld_sector_e;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] val;
  } hhld_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } hhld_fifo_stat_t;

  typedef struct packed {
    hhld_sector_e sector;
    logic [5:0]   off;
  } hhld_hue_t;

  // Split hue into 43-wide sectors; the top sector only reaches offset 40.
  function automatic hhld_hue_t hue_split(input logic [7:0] hue);
    hhld_hue_t   res;
    logic [7:0]  base;
    if (hue >= 8'd215) begin
      res.sector = SecMagenta;
      base       = 8'd215;
    end else if (hue >= 8'd172) begin
      res.sector = SecBlue;
      base       = 8'd172;
    end else if (hue >= 8'd129) begin
      res.sector = SecCyan;
      base       = 8'd129;
    end else if (hue >= 8'd86) begin
      res.sector = SecGreen;
      base       = 8'd86;
    end else if (hue >= SectorWidth) begin
      res.sector = SecYellow;
      base       = SectorWidth;
    end else begin
      res.sector = SecRed;
      base       = 8'd0;
    end
    res.off = 6'(hue - base);
    return res;
  endfunction

  // floor(x / 42) for x up to 10710
  function automatic logic [7:0] div42(input logic [13:0] x);
    logic [24:0] prod;
    prod = x[13:1] * Div21Mul;
    return prod[23:16];
  endfunction

  // floor(x / 255) for x up to 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] y;
    logic [24:0] s;
    y = {1'b0, x} + 17'd1;
    s = {y, 8'd0} + {8'd0, y};
    return s[23:16];
  endfunction

endpackage

/* rtl/heartbeat_hsv_led_driver.sv */
// ----------------------------------------------------------------------------
// heartbeat_hsv_led_driver
// Heartbeat triangle ramp with integer HSV to RGB PWM color output.
// ----------------------------------------------------------------------------
// Each accepted tick with a nonzero heartbeat color steps the brightness ramp
// in the same cycle and, when the tick is to be shown, queues it; ticks that
// show nothing leave no result. The front accepts one item per cycle while
// the queue has room, and the color pipeline behind it also takes one item
// per cycle while its output is not held, so the block sustains one item per
// clock while the master side takes its results. A shown item is written to
// the queue and then registered through the four color stages (sector split,
// divide by 42, value products, divide by 255 with output register) in turn
// before it appears on the master side. The whole back pipeline holds while
// a finished color waits to be taken. Configuration is written through the
// plain write port and takes effect on the next tick.
module heartbeat_hsv_led_driver #(
  parameter int FifoDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // beat_color[15:0], error_color[31:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // red[7:0], green[15:8], blue[23:16]
);
  import hhld_pkg::*;

  hhld_fifo_stat_t stat;
  hhld_entry_t     push_entry, pop_entry;
  logic            push, pop;

  hhld_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .stat_i        (stat),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  hhld_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_entry),
    .pop_i  (pop),
    .data_o (pop_entry),
    .stat_o (stat)
  );

  hhld_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stat_i        (stat),
    .entry_i       (pop_entry),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

/* rtl/hhld_fifo.sv */
// ----------------------------------------------------------------------------
// hhld_fifo
// Short queue of classified items between the ramp front and the color back.
// ----------------------------------------------------------------------------
`include "heartbeat_hsv_led_driver_assert.svh"

module hhld_fifo #(
  parameter int Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  hhld_pkg::hhld_entry_t    data_i,
  input  logic                     pop_i,
  output hhld_pkg::hhld_entry_t    data_o,
  output hhld_pkg::hhld_fifo_stat_t stat_o
);
  import hhld_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  hhld_entry_t           mem_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       count_q, count_d;
  logic                  do_push, do_pop;

  assign stat_o.full  = (count_q == CntW'(Depth));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign data_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `HHLD_ASSERT_NEVER(a_no_push_full, clk_i, rst_ni, push_i && stat_o.full)
  `HHLD_ASSERT_NEVER(a_no_pop_empty, clk_i, rst_ni, pop_i && stat_o.empty)
  `HHLD_ASSERT(a_count_step, clk_i, rst_ni,
    (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))

endmodule

/* rtl/hhld_front.sv */
// ----------------------------------------------------------------------------
// hhld_front
// Holds the configuration, steps the heartbeat ramp and queues items to show.
// ----------------------------------------------------------------------------
module hhld_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [7:0]                cfg_data_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [31:0]               s_axis_tdata,
  input  hhld_pkg::hhld_fifo_stat_t stat_i,
  output logic                      push_o,
  output hhld_pkg::hhld_entry_t     entry_o
);
  import hhld_pkg::*;

  logic [7:0]  sat_q, peak_q;
  logic [7:0]  level_q, level_d;
  logic        falling_q, falling_d;
  logic [15:0] beat, err;
  logic        take, fall, emit, err_mode;

  assign beat          = s_axis_tdata[15:0];
  assign err           = s_axis_tdata[31:16];
  assign s_axis_tready = !stat_i.full;
  assign take          = s_axis_tvalid && s_axis_tready && (beat != '0);
  assign err_mode      = (err != '0);

  always_comb begin
    fall = falling_q;
    if (level_q == peak_q) begin
      fall = 1'b1;
    end
    // zero test wins, so a peak of zero keeps rising and wraps
    if (level_q == '0) begin
      fall = 1'b0;
    end
    level_d   = fall ? level_q - 8'd1 : level_q + 8'd1;
    falling_d = fall;
    if (err_mode) begin
      emit = (level_d == peak_q) || (level_d == '0);
    end else begin
      emit = (level_d > 8'd1);
    end
  end

  assign push_o      = take && emit;
  assign entry_o.hue = err_mode ? err[7:0] : beat[7:0];
  assign entry_o.sat = sat_q;
  assign entry_o.val = level_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q     <= SatReset;
      peak_q    <= PeakReset;
      level_q   <= '0;
      falling_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (hhld_cfg_e'(cfg_idx_i))
          CfgSaturation: sat_q  <= cfg_data_i;
          CfgPeakLevel:  peak_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (take) begin
        level_q   <= level_d;
        falling_q <= falling_d;
      end
    end
  end

endmodule

/* rtl/hhld_back.sv */
// ----------------------------------------------------------------------------
// hhld_back
// Four-stage HSV to RGB pipeline with an output register on the master side.
// ----------------------------------------------------------------------------
module hhld_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  hhld_pkg::hhld_fifo_stat_t stat_i,
  input  hhld_pkg::hhld_entry_t     entry_i,
  output logic                      pop_o,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [23:0]               m_axis_tdata
);
  import hhld_pkg::*;

  logic         advance;
  logic         v1_q, v2_q, v3_q, out_valid_q;
  hhld_hue_t    hs;

  // stage 1: sector split and saturation products
  hhld_sector_e sec1_q;
  logic [7:0]   val1_q, ps1_q;
  logic         grey1_q;
  logic [13:0]  mo1_q, mt1_q;
  // stage 2: divide by 42, value times (255 - sat)
  hhld_sector_e sec2_q;
  logic [7:0]   val2_q, qd2_q, td2_q;
  logic         grey2_q;
  logic [15:0]  pv2_q;
  // stage 3: value times the q and t factors
  hhld_sector_e sec3_q;
  logic [7:0]   val3_q;
  logic         grey3_q;
  logic [15:0]  pv3_q, qv3_q, tv3_q;
  // stage 4: divide by 255 and route to channels
  logic [7:0]   p4, q4, t4, r4, g4, b4;
  logic [7:0]   red_q, green_q, blue_q;

  assign advance = !out_valid_q || m_axis_tready;
  assign pop_o   = advance && !stat_i.empty;
  assign hs      = hue_split(entry_i.hue);

  always_comb begin
    p4 = div255(pv3_q);
    q4 = div255(qv3_q);
    t4 = div255(tv3_q);
    if (grey3_q) begin
      r4 = val3_q;
      g4 = val3_q;
      b4 = val3_q;
    end else begin
      case (sec3_q)
        SecRed:     begin r4 = val3_q; g4 = t4;     b4 = p4;     end
        SecYellow:  begin r4 = q4;     g4 = val3_q; b4 = p4;     end
        SecGreen:   begin r4 = p4;     g4 = val3_q; b4 = t4;     end
        SecCyan:    begin r4 = p4;     g4 = q4;     b4 = val3_q; end
        SecBlue:    begin r4 = t4;     g4 = p4;     b4 = val3_q; end
        default:    begin r4 = val3_q; g4 = p4;     b4 = q4;     end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      v1_q        <= !stat_i.empty;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      sec1_q  <= hs.sector;
      val1_q  <= entry_i.val;
      grey1_q <= (entry_i.sat == '0);
      ps1_q   <= ValMax - entry_i.sat;
      mo1_q   <= entry_i.sat * hs.off;
      mt1_q   <= entry_i.sat * (SectorMax - hs.off);

      sec2_q  <= sec1_q;
      val2_q  <= val1_q;
      grey2_q <= grey1_q;
      qd2_q   <= div42(HsvFull - mo1_q);
      td2_q   <= div42(HsvFull - mt1_q);
      pv2_q   <= val1_q * ps1_q;

      sec3_q  <= sec2_q;
      val3_q  <= val2_q;
      grey3_q <= grey2_q;
      pv3_q   <= pv2_q;
      qv3_q   <= val2_q * qd2_q;
      tv3_q   <= val2_q * td2_q;

      red_q   <= r4;
      green_q <= g4;
      blue_q  <= b4;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {blue_q, green_q, red_q};

endmodule
